FILE: sv/sql_like_pattern_matcher_assert.svh
// Assertion macros for the LIKE pattern matcher.
`ifndef SQL_LIKE_PATTERN_MATCHER_ASSERT_SVH
`define SQL_LIKE_PATTERN_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, quiet while rst_n is low.
`define SLPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, clocked on clk, quiet while rst_n is low.
`define SLPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLPM_ASSERT_NOW(label, ante, cons, msg)
`define SLPM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: sv/slpm_pkg.sv
// Shared types, codes and helpers for the LIKE pattern matcher.
`default_nettype none

package slpm_pkg;

    localparam int SYM_W = 8;
    localparam int OP_W  = 2;

    // Request operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_TEXT   = 2'd2;
    localparam logic [OP_W-1:0] OP_EMPTY  = 2'd3;

    // Wildcards
    localparam logic [SYM_W-1:0] WILD_ONE = 8'h5F;  // '_'
    localparam logic [SYM_W-1:0] WILD_ANY = 8'h25;  // '%'

    localparam logic [SYM_W-1:0] UPPER_A  = 8'h41;
    localparam logic [SYM_W-1:0] UPPER_Z  = 8'h5A;
    localparam logic [SYM_W-1:0] CASE_GAP = 8'h20;

    // Per-request control broadcast to every cell
    typedef struct packed {
        logic clear;    // drop pattern
        logic append;   // add one pattern byte
        logic step;     // text byte, string continues
        logic restart;  // string ends (last byte or empty test)
    } ctrl_t;

    // Signals handed from one cell to the next
    typedef struct packed {
        logic valid;    // previous position holds a pattern byte
        logic fwd;      // previous position advances into this one
        logic carry;    // '%' closure rippling in from the left
        logic lead;     // start-state closure grows into this position
    } link_t;

    // End-of-pattern taps read by the top level
    typedef struct packed {
        logic step_hit;
        logic lead_hit;
    } tap_t;

    // ASCII-only case fold
    function automatic logic [SYM_W-1:0] fold(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] r;
        r = c;
        if (c >= UPPER_A && c <= UPPER_Z) begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/slpm_cell.sv
// One pattern position: stored byte, occupancy, active and start-closure bits.
`default_nettype none

module slpm_cell #(
    parameter logic HEAD = 1'b0
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire slpm_pkg::ctrl_t                 ctrl,
    input  wire logic [slpm_pkg::SYM_W-1:0]      symbol,
    input  wire slpm_pkg::link_t                 link_in,
    output slpm_pkg::link_t                      link_out,
    output slpm_pkg::tap_t                       tap
);

    logic [slpm_pkg::SYM_W-1:0] pat_reg;
    logic valid_reg, valid_next;
    logic act_reg, act_next;
    logic lead_reg, lead_next;
    logic wr, is_any, is_one, same, live, nv, knext, at_end;

    assign wr     = ctrl.append & ~valid_reg & link_in.valid;
    assign is_any = (pat_reg == slpm_pkg::WILD_ANY);
    assign is_one = (pat_reg == slpm_pkg::WILD_ONE);
    assign same   = (slpm_pkg::fold(pat_reg) == slpm_pkg::fold(symbol));
    assign live   = valid_reg & act_reg;

    // '%' keeps its own position; closure ripples in from the left
    assign nv     = (live & is_any) | link_in.fwd;
    assign knext  = nv | link_in.carry;
    assign at_end = link_in.valid & ~valid_reg;

    assign link_out.valid = valid_reg;
    assign link_out.fwd   = live & ~is_any & (is_one | same);
    assign link_out.carry = knext & valid_reg & is_any;
    assign link_out.lead  = wr & lead_reg & (symbol == slpm_pkg::WILD_ANY);

    assign tap.step_hit = knext & at_end;
    assign tap.lead_hit = lead_reg & at_end;

    always_comb
    begin
        valid_next = ctrl.clear ? 1'b0 : (valid_reg | wr);
        lead_next  = (ctrl.clear ? 1'b0 : lead_reg) | link_in.lead;
        act_next   = act_reg;
        if (ctrl.clear || ctrl.append)
        begin
            act_next = lead_next;
        end
        else if (ctrl.step)
        begin
            act_next = knext;
        end
        else if (ctrl.restart)
        begin
            act_next = lead_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            act_reg   <= HEAD;
            lead_reg  <= HEAD;
        end
        else
        begin
            valid_reg <= valid_next;
            act_reg   <= act_next;
            lead_reg  <= lead_next;
        end
    end

    // pattern byte: no reset, read only once occupied
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            pat_reg <= symbol;
        end
    end

endmodule

`default_nettype wire

FILE: sv/sql_like_pattern_matcher.sv
// Top level of the case-insensitive SQL LIKE pattern matcher.
`default_nettype none

// Matches text strings against a stored LIKE pattern, ASCII letters folded
// to lower case. A clear request empties the pattern; append requests add
// one byte each ('_' = any one byte, '%' = any run, possibly empty). Text
// requests carry one byte each; the byte flagged last produces one result.
// An empty-text request produces one result for the empty string. Any
// pattern request, or an empty-text request, abandons a string in flight.
// Appending beyond PATTERN_MAX bytes drops the byte; each later result
// until the next clear sets pattern_too_long and holds matched at 0.
// Structure: a row of PATTERN_MAX cells, one per pattern position, each
// holding its byte, an occupancy bit, its active bit and its bit of the
// start-state closure. Per text byte every cell advances in parallel and
// the '%' closure ripples across the row like a carry chain, so the block
// takes one request per clock; the result is registered and appears the
// cycle after the request that ends the string. A downstream stall holds
// the result register and stalls the input side only while it is full.
// The pattern bytes need no clearing pass: out of reset the block is ready.

module sql_like_pattern_matcher #(
    parameter int PATTERN_MAX = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request side
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [slpm_pkg::OP_W-1:0]     op,
    input  wire logic [slpm_pkg::SYM_W-1:0]    symbol,
    input  wire logic                          last,
    // result side
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               matched,
    output logic                               pattern_too_long
);

    slpm_pkg::ctrl_t ctrl;
    slpm_pkg::link_t links [PATTERN_MAX+1];
    slpm_pkg::tap_t  taps  [PATTERN_MAX];

    logic accept, produce;
    logic step_any, lead_any;
    logic lead_end_reg, lead_end_next;
    logic ovf_reg, ovf_next;
    logic out_valid_reg, out_valid_next;
    logic matched_reg, too_long_reg;
    logic result_bit;

    // result register full and stalled: hold the request side
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        ctrl = '0;
        if (accept)
        begin
            case (op)
                slpm_pkg::OP_CLEAR:  ctrl.clear   = 1'b1;
                slpm_pkg::OP_APPEND: ctrl.append  = 1'b1;
                slpm_pkg::OP_TEXT:
                begin
                    ctrl.step    = ~last;
                    ctrl.restart = last;
                end
                slpm_pkg::OP_EMPTY:  ctrl.restart = 1'b1;
                default:             ctrl = '0;
            endcase
        end
    end

    assign produce = ctrl.restart;

    // head of the row: position zero is always reachable from the start
    assign links[0].valid = 1'b1;
    assign links[0].fwd   = 1'b0;
    assign links[0].carry = 1'b0;
    assign links[0].lead  = 1'b1;

    for (genvar g = 0; g < PATTERN_MAX; g++)
    begin : g_cell
        slpm_cell #(
            .HEAD (g == 0)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .symbol   (symbol),
            .link_in  (links[g]),
            .link_out (links[g+1]),
            .tap      (taps[g])
        );
    end

    // Position PATTERN_MAX: only reached with a full pattern. Its active
    // bit is never advanced from, so only its start-closure bit is kept.
    always_comb
    begin
        step_any = (links[PATTERN_MAX].fwd | links[PATTERN_MAX].carry)
                   & links[PATTERN_MAX].valid;
        lead_any = lead_end_reg & links[PATTERN_MAX].valid;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            step_any = step_any | taps[i].step_hit;
            lead_any = lead_any | taps[i].lead_hit;
        end
    end

    assign lead_end_next = (ctrl.clear ? 1'b0 : lead_end_reg) | links[PATTERN_MAX].lead;

    // append with every cell occupied overflows the store
    assign ovf_next = ctrl.clear ? 1'b0
                    : (ovf_reg | (ctrl.append & links[PATTERN_MAX].valid));

    assign result_bit     = (op == slpm_pkg::OP_EMPTY) ? lead_any : step_any;
    assign out_valid_next = produce | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_end_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lead_end_reg  <= lead_end_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            matched_reg  <= result_bit & ~ovf_reg;
            too_long_reg <= ovf_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_too_long = too_long_reg;

`include "sql_like_pattern_matcher_assert.svh"

    `SLPM_ASSERT_NEXT(a_empty_gives_result, accept && (op == slpm_pkg::OP_EMPTY), out_valid_reg, "empty-text request produced no result")
    `SLPM_ASSERT_NOW(a_ovf_needs_full, ovf_reg, links[PATTERN_MAX].valid, "overflow with pattern store not full")
    `SLPM_ASSERT_NOW(a_too_long_no_match, out_valid_reg && pattern_too_long, !matched, "match reported for overlong pattern")
    `SLPM_ASSERT_NEXT(a_clear_empties, accept && (op == slpm_pkg::OP_CLEAR), !links[1].valid && !ovf_reg, "clear left pattern state behind")

endmodule

`default_nettype wire
